[rtl/core/tga_pkg.sv]
// Shared types and constants for the TGA run-length image decoder.
// No dependencies.
package tga_pkg;

  typedef enum logic [2:0] {
    PH_HEADER   = 3'd0,
    PH_PLAIN    = 3'd1,
    PH_PKT_HDR  = 3'd2,
    PH_PKT_DATA = 3'd3,
    PH_DONE     = 3'd4,
    PH_FAILED   = 3'd5
  } phase_t;

  localparam logic [1:0] KIND_INFO  = 2'd0;
  localparam logic [1:0] KIND_PIXEL = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [1:0] ERR_SHORT     = 2'd0;
  localparam logic [1:0] ERR_SIZE      = 2'd1;
  localparam logic [1:0] ERR_SIGNATURE = 2'd2;

  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [1:0]  error_code;
    logic [31:0] pixel_color;
    logic [7:0]  run_length;
    logic [31:0] start_index;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [5:0]  source_depth;
    logic        image_end;
  } result_t;

endpackage

[rtl/core/tga_rle_image_decoder.sv]
// Top level of the TGA image decoder: byte parser front, result queue back.
// Depends on tga_pkg, tga_front, tga_queue.
//
// channel | dir | ports
// --------+-----+-------------------------------------------------------
// input   | in  | in_valid, in_stall(out), in_data_byte, in_last_byte
// result  | out | out_valid, out_stall(in), out_result_kind ... out_image_end
//
// One byte is taken per cycle while in_stall is low; the parser updates
// its counters and builds at most one result item in the same cycle and
// writes it to the queue. Results leave through the queue's registered head.
// in_stall rises only when the queue is full (output stalled).
// Reset (rst_n low, synchronous) returns to the header phase, empties queue.
module tga_rle_image_decoder #(
  parameter int QueueDepth = tga_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_result_kind,
  output logic [1:0]  out_error_code,
  output logic [31:0] out_pixel_color,
  output logic [7:0]  out_run_length,
  output logic [31:0] out_start_index,
  output logic [15:0] out_image_width,
  output logic [15:0] out_image_height,
  output logic [5:0]  out_source_depth,
  output logic        out_image_end
);

  logic             room, res_valid, take;
  tga_pkg::result_t res, head;

  assign in_stall = !room;
  assign take     = in_valid && room;

  tga_front u_front (
    .clk, .rst_n, .byte_valid(take), .data_byte(in_data_byte),
    .last_byte(in_last_byte), .res_valid, .res
  );

  tga_queue #(.Depth(QueueDepth)) u_queue (
    .clk, .rst_n, .wr_en(res_valid), .wr_data(res), .room,
    .rd_valid(out_valid), .rd_stall(out_stall), .rd_data(head)
  );

  assign out_result_kind  = head.result_kind;
  assign out_error_code   = head.error_code;
  assign out_pixel_color  = head.pixel_color;
  assign out_run_length   = head.run_length;
  assign out_start_index  = head.start_index;
  assign out_image_width  = head.image_width;
  assign out_image_height = head.image_height;
  assign out_source_depth = head.source_depth;
  assign out_image_end    = head.image_end;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_start_index))
    else $error("stalled result changed");

endmodule

[rtl/core/tga_front.sv]
// Front part: byte parser. Runs header, packet and pixel bookkeeping at
// one byte per cycle while byte_valid is high and produces finished
// result items. Depends on tga_pkg.
module tga_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                byte_valid,
  input  logic [7:0]          data_byte,
  input  logic                last_byte,
  output logic                res_valid,
  output tga_pkg::result_t    res
);

  tga_pkg::phase_t phase_r, phase_nxt;
  logic [4:0]  hpos_r, hpos_nxt;
  logic        plain_ok_r, plain_ok_nxt, run_ok_r, run_ok_nxt;
  logic [15:0] width_r, width_nxt, height_r, height_nxt;
  logic [5:0]  depth_r, depth_nxt;
  logic [31:0] total_r, total_nxt, done_r, done_nxt;
  logic [7:0]  left_r, left_nxt;
  logic        is_run_r, is_run_nxt;
  logic [1:0]  bip_r, bip_nxt;
  logic [31:0] gather_r, gather_nxt;

  logic [8:0]  count9;
  logic [32:0] sum33;
  logic [31:0] gathered, color, cnt32, done_add;
  logic [7:0]  cnt8;
  logic        complete;

  always_comb begin
    phase_nxt = phase_r; hpos_nxt = hpos_r;
    plain_ok_nxt = plain_ok_r; run_ok_nxt = run_ok_r;
    width_nxt = width_r; height_nxt = height_r; depth_nxt = depth_r;
    total_nxt = total_r; done_nxt = done_r; left_nxt = left_r;
    is_run_nxt = is_run_r; bip_nxt = bip_r; gather_nxt = gather_r;
    res_valid = 1'b0;
    res = '0;
    count9 = '0; sum33 = '0; gathered = '0; color = '0;
    cnt32 = '0; done_add = '0; cnt8 = '0; complete = 1'b0;
    if (byte_valid) begin
      case (phase_r)
        tga_pkg::PH_HEADER: begin
          if (hpos_r < 5'd12) begin
            if (data_byte != ((hpos_r == 5'd2) ? 8'd2 : 8'd0)) plain_ok_nxt = 1'b0;
            if (data_byte != ((hpos_r == 5'd2) ? 8'd10 : 8'd0)) run_ok_nxt = 1'b0;
          end else if (hpos_r == 5'd12) width_nxt = {8'd0, data_byte};
          else if (hpos_r == 5'd13) width_nxt = {data_byte, width_r[7:0]};
          else if (hpos_r == 5'd14) height_nxt = {8'd0, data_byte};
          else if (hpos_r == 5'd15) height_nxt = {data_byte, height_r[7:0]};
          else if (hpos_r == 5'd16)
            depth_nxt = (data_byte == 8'd24 || data_byte == 8'd32) ? data_byte[5:0] : 6'd0;
          if (hpos_r < 5'd18) hpos_nxt = hpos_r + 5'd1;
          if (last_byte) begin
            res_valid = 1'b1; res.result_kind = tga_pkg::KIND_ERROR;
            res.error_code = tga_pkg::ERR_SHORT; phase_nxt = tga_pkg::PH_FAILED;
          end else if (hpos_r == 5'd17) begin
            res_valid = 1'b1;
            if (width_r == 16'd0 || height_r == 16'd0 || depth_r == 6'd0) begin
              res.result_kind = tga_pkg::KIND_ERROR;
              res.error_code = tga_pkg::ERR_SIZE; phase_nxt = tga_pkg::PH_FAILED;
            end else if (!plain_ok_r && !run_ok_r) begin
              res.result_kind = tga_pkg::KIND_ERROR;
              res.error_code = tga_pkg::ERR_SIGNATURE; phase_nxt = tga_pkg::PH_FAILED;
            end else begin
              // one 16x16 multiply, registered straight into total_r
              total_nxt = width_r * height_r;
              done_nxt = '0; bip_nxt = '0; gather_nxt = '0;
              phase_nxt = plain_ok_r ? tga_pkg::PH_PLAIN : tga_pkg::PH_PKT_HDR;
              res.result_kind = tga_pkg::KIND_INFO;
              res.image_width = width_r; res.image_height = height_r;
              res.source_depth = depth_r;
            end
          end
        end
        tga_pkg::PH_PKT_HDR: begin
          is_run_nxt = data_byte[7];
          count9 = data_byte[7] ? {1'b0, data_byte} - 9'd127 : {1'b0, data_byte} + 9'd1;
          sum33 = {1'b0, done_r} + {24'd0, count9};
          if (sum33 > {1'b0, total_r} || last_byte) begin
            res_valid = 1'b1; res.result_kind = tga_pkg::KIND_ERROR;
            res.error_code = tga_pkg::ERR_SHORT; phase_nxt = tga_pkg::PH_FAILED;
          end else begin
            left_nxt = count9[7:0]; bip_nxt = '0; gather_nxt = '0;
            phase_nxt = tga_pkg::PH_PKT_DATA;
          end
        end
        tga_pkg::PH_PLAIN, tga_pkg::PH_PKT_DATA: begin
          case (bip_r)
            2'd0: gathered = gather_r | {8'd0, data_byte, 16'd0};
            2'd1: gathered = gather_r | {16'd0, data_byte, 8'd0};
            2'd2: gathered = gather_r | {24'd0, data_byte};
            default: gathered = gather_r | {data_byte, 24'd0};
          endcase
          gather_nxt = gathered;
          bip_nxt = bip_r + 2'd1;
          complete = ({1'b0, bip_r} + 3'd1) >= {1'b0, depth_r[4:3]} + 3'(depth_r[5] ? 4 : 0);
          if (complete) begin
            color = (depth_r == 6'd24) ? {8'hff, gathered[23:0]} : gathered;
            cnt8 = (phase_r == tga_pkg::PH_PKT_DATA && is_run_r) ? left_r : 8'd1;
            cnt32 = {24'd0, cnt8};
            done_add = done_r + cnt32;
            res_valid = 1'b1;
            res.result_kind = tga_pkg::KIND_PIXEL;
            res.pixel_color = color; res.run_length = cnt8;
            res.start_index = done_r;
            res.image_width = width_r; res.image_height = height_r;
            res.source_depth = depth_r;
            done_nxt = done_add; bip_nxt = '0; gather_nxt = '0;
            if (phase_r == tga_pkg::PH_PKT_DATA) begin
              left_nxt = is_run_r ? 8'd0 : left_r - 8'd1;
              if (left_nxt == 8'd0) phase_nxt = tga_pkg::PH_PKT_HDR;
            end
            if (done_add >= total_r) begin
              phase_nxt = tga_pkg::PH_DONE; res.image_end = 1'b1;
            end
          end
          if (last_byte && phase_nxt != tga_pkg::PH_DONE) begin
            res_valid = 1'b1; res = '0;
            res.result_kind = tga_pkg::KIND_ERROR;
            res.error_code = tga_pkg::ERR_SHORT; phase_nxt = tga_pkg::PH_FAILED;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= tga_pkg::PH_HEADER; hpos_r <= '0;
      plain_ok_r <= 1'b1; run_ok_r <= 1'b1;
      width_r <= '0; height_r <= '0; depth_r <= '0;
      total_r <= '0; done_r <= '0; left_r <= '0; is_run_r <= 1'b0;
      bip_r <= '0; gather_r <= '0;
    end else begin
      phase_r <= phase_nxt; hpos_r <= hpos_nxt;
      plain_ok_r <= plain_ok_nxt; run_ok_r <= run_ok_nxt;
      width_r <= width_nxt; height_r <= height_nxt; depth_r <= depth_nxt;
      total_r <= total_nxt; done_r <= done_nxt; left_r <= left_nxt;
      is_run_r <= is_run_nxt; bip_r <= bip_nxt; gather_r <= gather_nxt;
    end
  end

  a_fail_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == tga_pkg::PH_FAILED |=> phase_r == tga_pkg::PH_FAILED)
    else $error("failed phase left");
  a_done_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == tga_pkg::PH_PKT_DATA || phase_r == tga_pkg::PH_PKT_HDR) |-> done_r < total_r)
    else $error("pixel count past total");
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !byte_valid |-> !res_valid)
    else $error("result without byte");

endmodule

[rtl/core/tga_queue.sv]
// Result queue between parser and output channel, with registered head.
// Depends on tga_pkg.
module tga_queue #(
  parameter int Depth = tga_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  tga_pkg::result_t wr_data,
  output logic             room,
  output logic             rd_valid,
  input  logic             rd_stall,
  output tga_pkg::result_t rd_data
);
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  tga_pkg::result_t mem [Depth];
  tga_pkg::result_t head_r;
  logic [AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [AW:0]   cnt_r, cnt_nxt;
  logic          rd_en;

  assign rd_valid = cnt_r != '0;
  assign rd_data  = head_r;
  // the parser writes in the cycle it takes a byte, so one free slot is enough
  assign room     = cnt_r < (AW+1)'(Depth);
  assign rd_en    = rd_valid && !rd_stall;

  always_comb begin
    wp_nxt = wp_r; rp_nxt = rp_r;
    if (wr_en) wp_nxt = (wp_r == AW'(Depth - 1)) ? '0 : wp_r + 1'b1;
    if (rd_en) rp_nxt = (rp_r == AW'(Depth - 1)) ? '0 : rp_r + 1'b1;
    cnt_nxt = cnt_r + (AW+1)'(wr_en) - (AW+1)'(rd_en);
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wp_r] <= wr_data;
    // head tracks the next read slot; a write into that slot passes straight through
    if (wr_en && wp_r == rp_nxt) head_r <= wr_data;
    else head_r <= mem[rp_nxt];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      wp_r <= wp_nxt; rp_r <= rp_nxt; cnt_r <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> cnt_r < (AW+1)'(Depth) || rd_en)
    else $error("queue overflow");
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (AW+1)'(Depth))
    else $error("queue count out of range");

endmodule

[tb/tb.sv]
// Self-checking bench for tga_rle_image_decoder: one run-length, 32-bit image
// is streamed in byte by byte and every result item is checked against a predictor.
// Depends on tga_pkg and the decoder RTL.
`timescale 1ns / 100ps

class tga_decode_board;
  tga_pkg::phase_t phase;
  int unsigned     hdr_pos;
  bit              plain_ok, run_ok, pkt_run;
  bit [15:0]       width_r, height_r;
  bit [5:0]        depth_r;
  bit [31:0]       px_total, px_done, gather;
  bit [7:0]        pkt_left;
  bit [1:0]        byte_idx;
  tga_pkg::result_t decoded_q[$];
  int              errors, checked;

  function new();
    phase = tga_pkg::PH_HEADER;
    hdr_pos = 0; plain_ok = 1; run_ok = 1; pkt_run = 0;
    width_r = 0; height_r = 0; depth_r = 0;
    px_total = 0; px_done = 0; gather = 0; pkt_left = 0; byte_idx = 0;
    errors = 0; checked = 0;
  endfunction

  function void push_error(logic [1:0] code);
    tga_pkg::result_t r;
    r = '0;
    r.result_kind = tga_pkg::KIND_ERROR;
    r.error_code = code;
    decoded_q.push_back(r);
    phase = tga_pkg::PH_FAILED;
  endfunction

  // Accepted input byte: advance the decoder state, queue any result it gives.
  function void note_byte(bit [7:0] b, bit last);
    tga_pkg::result_t r;
    int unsigned pos, nbytes, sh;
    bit [31:0] cnt, colr;
    bit got;
    r = '0;
    got = 0;
    case (phase)
      tga_pkg::PH_HEADER: begin
        pos = hdr_pos;
        if (pos < 12) begin
          if (b != ((pos == 2) ? 8'd2 : 8'd0)) plain_ok = 0;
          if (b != ((pos == 2) ? 8'd10 : 8'd0)) run_ok = 0;
        end else if (pos == 12) width_r = {8'd0, b};
        else if (pos == 13) width_r[15:8] = b;
        else if (pos == 14) height_r = {8'd0, b};
        else if (pos == 15) height_r[15:8] = b;
        else if (pos == 16) depth_r = (b == 24 || b == 32) ? b[5:0] : 6'd0;
        if (hdr_pos < 18) hdr_pos++;
        if (last) push_error(tga_pkg::ERR_SHORT);
        else if (pos == 17) begin
          if (width_r == 0 || height_r == 0 || depth_r == 0)
            push_error(tga_pkg::ERR_SIZE);
          else if (!plain_ok && !run_ok) push_error(tga_pkg::ERR_SIGNATURE);
          else begin
            px_total = width_r * height_r;
            px_done = 0; byte_idx = 0; gather = 0;
            phase = plain_ok ? tga_pkg::PH_PLAIN : tga_pkg::PH_PKT_HDR;
            r.result_kind = tga_pkg::KIND_INFO;
            r.image_width = width_r; r.image_height = height_r;
            r.source_depth = depth_r;
            decoded_q.push_back(r);
          end
        end
      end
      tga_pkg::PH_PKT_HDR: begin
        pkt_run = b[7];
        cnt = pkt_run ? b - 127 : b + 1;
        if ({1'b0, px_done} + cnt > {1'b0, px_total}) push_error(tga_pkg::ERR_SHORT);
        else begin
          pkt_left = cnt[7:0]; byte_idx = 0; gather = 0;
          phase = tga_pkg::PH_PKT_DATA;
          if (last) push_error(tga_pkg::ERR_SHORT);
        end
      end
      tga_pkg::PH_PLAIN, tga_pkg::PH_PKT_DATA: begin
        nbytes = depth_r / 8;
        sh = (byte_idx == 0) ? 16 : (byte_idx == 1) ? 8 : (byte_idx == 2) ? 0 : 24;
        gather |= {24'd0, b} << sh;
        if (byte_idx + 1 >= nbytes) begin
          colr = gather;
          cnt = 1;
          if (nbytes == 3) colr = {8'hff, colr[23:0]};
          if (phase == tga_pkg::PH_PKT_DATA && pkt_run) cnt = pkt_left;
          r.result_kind = tga_pkg::KIND_PIXEL;
          r.pixel_color = colr; r.run_length = cnt[7:0]; r.start_index = px_done;
          r.image_width = width_r; r.image_height = height_r;
          r.source_depth = depth_r;
          px_done += cnt;
          byte_idx = 0; gather = 0;
          if (phase == tga_pkg::PH_PKT_DATA) begin
            pkt_left = pkt_run ? 8'd0 : pkt_left - 8'd1;
            if (pkt_left == 0) phase = tga_pkg::PH_PKT_HDR;
          end
          if (px_done >= px_total) begin
            phase = tga_pkg::PH_DONE;
            r.image_end = 1;
          end
          got = 1;
        end else byte_idx = byte_idx + 2'd1;
        // a short stream replaces any pixel item with the error
        if (last && phase != tga_pkg::PH_DONE) push_error(tga_pkg::ERR_SHORT);
        else if (got) decoded_q.push_back(r);
      end
      default: ;
    endcase
  endfunction

  function void check_result(tga_pkg::result_t a);
    tga_pkg::result_t e;
    checked++;
    if (decoded_q.size() == 0) begin
      $error("unexpected result item, kind %0d", a.result_kind);
      errors++;
      return;
    end
    e = decoded_q.pop_front();
    if (a.result_kind !== e.result_kind) begin
      $error("result_kind exp %0d got %0d", e.result_kind, a.result_kind); errors++;
    end
    if (a.error_code !== e.error_code) begin
      $error("error_code exp %0d got %0d", e.error_code, a.error_code); errors++;
    end
    if (a.pixel_color !== e.pixel_color) begin
      $error("pixel_color exp %h got %h", e.pixel_color, a.pixel_color); errors++;
    end
    if (a.run_length !== e.run_length) begin
      $error("run_length exp %0d got %0d", e.run_length, a.run_length); errors++;
    end
    if (a.start_index !== e.start_index) begin
      $error("start_index exp %0d got %0d", e.start_index, a.start_index); errors++;
    end
    if (a.image_width !== e.image_width) begin
      $error("image_width exp %0d got %0d", e.image_width, a.image_width); errors++;
    end
    if (a.image_height !== e.image_height) begin
      $error("image_height exp %0d got %0d", e.image_height, a.image_height); errors++;
    end
    if (a.source_depth !== e.source_depth) begin
      $error("source_depth exp %0d got %0d", e.source_depth, a.source_depth); errors++;
    end
    if (a.image_end !== e.image_end) begin
      $error("image_end exp %0d got %0d", e.image_end, a.image_end); errors++;
    end
  endfunction
endclass

module tb;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 0;
  logic        in_last_byte = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [1:0]  out_result_kind, out_error_code;
  logic [31:0] out_pixel_color, out_start_index;
  logic [7:0]  out_run_length;
  logic [15:0] out_image_width, out_image_height;
  logic [5:0]  out_source_depth;
  logic        out_image_end;

  tga_decode_board board = new();
  bit [7:0]    pixel_bytes[$];   // packet stream after the header
  int unsigned n_pixels = 0;
  int unsigned n_bytes = 0;
  int unsigned n_pkts = 0;
  bit          burst = 0;        // no random idling on either side while set
  bit          stream_done = 0;

  tga_rle_image_decoder uut (
    .clk, .rst_n, .in_valid, .in_stall, .in_data_byte, .in_last_byte,
    .out_valid, .out_stall, .out_result_kind, .out_error_code,
    .out_pixel_color, .out_run_length, .out_start_index, .out_image_width,
    .out_image_height, .out_source_depth, .out_image_end
  );

  always #10 clk = ~clk;

  // Monitors: everything is sampled at the rising edge.
  always @(posedge clk) begin
    tga_pkg::result_t r;
    if (rst_n && in_valid && !in_stall) begin
      board.note_byte(in_data_byte, in_last_byte);
      n_bytes++;
    end
    if (rst_n && out_valid && !out_stall) begin
      r.result_kind = out_result_kind;   r.error_code = out_error_code;
      r.pixel_color = out_pixel_color;   r.run_length = out_run_length;
      r.start_index = out_start_index;   r.image_width = out_image_width;
      r.image_height = out_image_height; r.source_depth = out_source_depth;
      r.image_end = out_image_end;
      board.check_result(r);
    end
  end

  // One packet: header byte then its colour bytes (B,G,R,A); col_mode picks
  // all-zero, all-ones or random colour content.
  task automatic add_packet(input bit [7:0] hdr, input int col_mode);
    int unsigned cnt, k;
    cnt = hdr[7] ? 1 : hdr + 1;
    pixel_bytes.push_back(hdr);
    for (int p = 0; p < cnt; p++)
      for (k = 0; k < 4; k++)
        pixel_bytes.push_back(col_mode == 0 ? 8'h00 : col_mode == 1 ? 8'hff
                              : 8'($urandom));
    n_pixels += hdr[7] ? hdr - 127 : hdr + 1;
    n_pkts++;
  endtask

  // Drive one byte at the falling edge and hold it until taken.
  task automatic send_byte(input bit [7:0] b, input bit l);
    int unsigned gap;
    gap = burst ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1;
    in_data_byte <= b;
    in_last_byte <= l;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Receiver: random stall per item, one long hold-off after some results so
  // the queue fills and the input side backs up.
  initial begin : receiver
    int unsigned gap, taken;
    bit held;
    taken = 0;
    held = 0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (!held && taken == 40) begin
        held = 1;
        out_stall <= 1;
        repeat (300) @(negedge clk);
      end else begin
        gap = burst ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
          out_stall <= 1;
          repeat (gap) @(negedge clk);
        end
      end
      out_stall <= 0;
      do @(posedge clk); while (!out_valid);
      taken++;
      @(negedge clk);
    end
  end

  initial begin : sender
    bit [7:0] hdr;
    int unsigned wait_cyc;
    repeat (4) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // Directed packets: single raw pixel, shortest and longest runs, longest
    // raw packet, colours all-zero and all-ones.
    add_packet(8'h00, 0);
    add_packet(8'h80, 1);
    add_packet(8'hff, 2);
    add_packet(8'h00, 1);
    add_packet(8'hfe, 0);
    add_packet(8'h7f, 2);
    // Random packets: mostly short raw packets, runs of any length.
    while (pixel_bytes.size() < 1400) begin
      if ($urandom_range(0, 9) < 7) hdr = 8'($urandom_range(0, 7));
      else hdr = 8'($urandom_range(128, 255));
      add_packet(hdr, 2);
    end

    // Header: run-length signature, width = all pixels, height 1, 32 bpp.
    for (int i = 0; i < 12; i++) send_byte(i == 2 ? 8'd10 : 8'd0, 0);
    send_byte(n_pixels[7:0], 0);
    send_byte(n_pixels[15:8], 0);
    send_byte(8'd1, 0);
    send_byte(8'd0, 0);
    send_byte(8'd32, 0);
    send_byte(8'($urandom), 0);

    foreach (pixel_bytes[i]) begin
      if (i % 100 == 0) burst = ($urandom_range(0, 3) == 0);
      send_byte(pixel_bytes[i], i == pixel_bytes.size() - 1);
    end
    burst = 0;
    // trailing bytes after the completed image are ignored
    for (int i = 0; i < 4; i++) send_byte(8'($urandom), 1'($urandom));
    in_valid <= 0;

    wait_cyc = 0;
    while (board.decoded_q.size() != 0 && wait_cyc < 20000) begin
      @(negedge clk);
      wait_cyc++;
    end
    repeat (20) @(negedge clk);
    if (board.decoded_q.size() != 0) begin
      $error("%0d result items never arrived", board.decoded_q.size());
      board.errors++;
    end
    $display("tb: %0d bytes fed, %0d packets, %0d pixels in one 32-bit RLE image",
             n_bytes, n_pkts, n_pixels);
    $display("tb: %0d result items checked, %0d mismatches", board.checked,
             board.errors);
    if (board.errors == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

  initial begin : watchdog
    #20ms;
    $display("tb: FAIL");
    $finish;
  end
endmodule

[filelist.f]
rtl/core/tga_pkg.sv
rtl/core/tga_front.sv
rtl/core/tga_queue.sv
rtl/core/tga_rle_image_decoder.sv
tb/tb.sv
